FILE: sv/pool_linked_list_manager_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pool linked list manager
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef POOL_LINKED_LIST_MANAGER_MACROS_SVH
`define POOL_LINKED_LIST_MANAGER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off during reset
`define PLLM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("pool list manager check failed");

// next-cycle implication
`define PLLM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("pool list manager check failed");

`else

`define PLLM_ASSERT_IMPL(label, ante, cons)
`define PLLM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: sv/pllm_pkg.sv
// ----------------------------------------------------------------------------
// pllm_pkg
// Types and constants of the pool linked list manager.
// ----------------------------------------------------------------------------
`default_nettype none

package pllm_pkg;

	localparam int unsigned MAX_ENTRIES = 256;
	localparam int unsigned ENTRY_W     = $clog2(MAX_ENTRIES);
	localparam int unsigned COUNT_W     = ENTRY_W + 1;

	typedef enum logic [2:0] {
		OP_ALLOC_HEAD = 3'd0,
		OP_ALLOC_TAIL = 3'd1,
		OP_FREE       = 3'd2,
		OP_NEXT       = 3'd3,
		OP_CHECK      = 3'd4
	} pllm_op_t;

	typedef struct packed {
		pllm_op_t           op;
		logic [ENTRY_W-1:0] entry_index;
		logic               from_start;
	} pllm_req_t;

	typedef struct packed {
		logic               ok;
		logic [ENTRY_W-1:0] result_index;
		logic [COUNT_W-1:0] in_use_count;
	} pllm_rsp_t;

endpackage

`default_nettype wire

FILE: sv/pool_linked_list_manager.sv
// ----------------------------------------------------------------------------
// pool_linked_list_manager
// Fixed pool of entry indices: doubly linked in-use list plus a free FIFO.
// ----------------------------------------------------------------------------
// The transfer cycle of a request launches the link memory reads (next and
// prev at entry_index, free link at the free head), and the following cycle
// updates the lists, writes at most one entry of each link memory and loads
// the response register. No new request is taken while that update is
// pending, and one is taken only when the response register is free or is
// drained in that cycle. Writing pool_size empties the pool at once; there is
// no clearing pass. List ends are tracked in registers, so the outer links at
// the head and tail never need to be valid.
`default_nettype none

`include "pool_linked_list_manager_macros.svh"

module pool_linked_list_manager (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              req_valid,
	output logic                             req_ready,
	input  pllm_pkg::pllm_req_t              req,
	output logic                             rsp_valid,
	input  wire                              rsp_ready,
	output pllm_pkg::pllm_rsp_t              rsp,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [pllm_pkg::COUNT_W-1:0]     cfg_data
);

	localparam int unsigned IW = pllm_pkg::ENTRY_W;
	localparam int unsigned CW = pllm_pkg::COUNT_W;
	localparam int unsigned NE = pllm_pkg::MAX_ENTRIES;

	// link memories
	logic [IW-1:0] next_mem [NE];
	logic [IW-1:0] prev_mem [NE];
	logic [IW-1:0] free_mem [NE];

	pllm_pkg::pllm_req_t item_s1;
	logic [IW-1:0] next_rd_s1, prev_rd_s1, free_rd_s1;

	logic          busy_q;
	logic [NE-1:0] in_use_q;
	logic [IW-1:0] list_head_q, list_tail_q, free_head_q, free_tail_q;
	logic          free_empty_q;
	logic [CW-1:0] fresh_next_q, used_total_q, pool_size_q;
	logic          rsp_valid_q;
	pllm_pkg::pllm_rsp_t rsp_q;

	logic req_xfer, cfg_xfer, rsp_xfer;

	// update decoded from the registered request
	logic          ok_c;
	logic [IW-1:0] res_c;
	logic          next_we, prev_we, free_we, flag_we, flag_wd;
	logic [IW-1:0] next_wa, next_wd, prev_wa, prev_wd, free_wa, free_wd, flag_wa;
	logic [IW-1:0] head_d, tail_d, fhead_d, ftail_d;
	logic          fempty_d;
	logic [CW-1:0] fresh_d, used_d;
	logic [CW-1:0] cfg_size;

	logic          list_empty, idx_used, fresh_avail, can_alloc, is_head, is_tail;
	logic [IW-1:0] idx, alloc_e;

	assign req_ready = !busy_q && (!rsp_valid_q || rsp_ready);
	assign cfg_ready = !busy_q;
	assign req_xfer  = req_valid && req_ready;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign rsp_xfer  = rsp_valid_q && rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		if (cfg_data == '0)
			cfg_size = CW'(1);
		else if (cfg_data > CW'(NE))
			cfg_size = CW'(NE);
		else
			cfg_size = cfg_data;
	end

	always_comb begin
		idx         = item_s1.entry_index;
		list_empty  = (used_total_q == '0);
		idx_used    = ({1'b0, idx} < pool_size_q) && in_use_q[idx];
		fresh_avail = (fresh_next_q < pool_size_q);
		can_alloc   = fresh_avail || !free_empty_q;
		alloc_e     = fresh_avail ? fresh_next_q[IW-1:0] : free_head_q;
		is_head     = (idx == list_head_q);
		is_tail     = (idx == list_tail_q);

		ok_c     = 1'b0;
		res_c    = '0;
		next_we  = 1'b0;
		next_wa  = idx;
		next_wd  = '0;
		prev_we  = 1'b0;
		prev_wa  = idx;
		prev_wd  = '0;
		free_we  = 1'b0;
		free_wa  = free_tail_q;
		free_wd  = idx;
		flag_we  = 1'b0;
		flag_wa  = idx;
		flag_wd  = 1'b0;
		head_d   = list_head_q;
		tail_d   = list_tail_q;
		fhead_d  = free_head_q;
		ftail_d  = free_tail_q;
		fempty_d = free_empty_q;
		fresh_d  = fresh_next_q;
		used_d   = used_total_q;

		case (item_s1.op)
			pllm_pkg::OP_ALLOC_HEAD, pllm_pkg::OP_ALLOC_TAIL: begin
				if (can_alloc) begin
					// never-used entries first, then the free FIFO
					if (fresh_avail)
						fresh_d = fresh_next_q + 1'b1;
					else if (free_head_q == free_tail_q)
						fempty_d = 1'b1;
					else
						fhead_d = free_rd_s1;
					if (item_s1.op == pllm_pkg::OP_ALLOC_HEAD) begin
						next_we = 1'b1;
						next_wa = alloc_e;
						next_wd = list_head_q;
						if (!list_empty) begin
							prev_we = 1'b1;
							prev_wa = list_head_q;
							prev_wd = alloc_e;
						end else begin
							tail_d = alloc_e;
						end
						head_d = alloc_e;
					end else begin
						prev_we = 1'b1;
						prev_wa = alloc_e;
						prev_wd = list_tail_q;
						if (!list_empty) begin
							next_we = 1'b1;
							next_wa = list_tail_q;
							next_wd = alloc_e;
						end else begin
							head_d = alloc_e;
						end
						tail_d = alloc_e;
					end
					flag_we = 1'b1;
					flag_wa = alloc_e;
					flag_wd = 1'b1;
					used_d  = used_total_q + 1'b1;
					ok_c    = 1'b1;
					res_c   = alloc_e;
				end
			end
			pllm_pkg::OP_FREE: begin
				if (idx_used) begin
					// unlink from the in-use list
					if (!is_tail) begin
						prev_we = 1'b1;
						prev_wa = next_rd_s1;
						prev_wd = prev_rd_s1;
					end else begin
						tail_d = prev_rd_s1;
					end
					if (!is_head) begin
						next_we = 1'b1;
						next_wa = prev_rd_s1;
						next_wd = next_rd_s1;
					end else begin
						head_d = next_rd_s1;
					end
					// append to the free FIFO
					if (!free_empty_q)
						free_we = 1'b1;
					else
						fhead_d = idx;
					ftail_d  = idx;
					fempty_d = 1'b0;
					flag_we  = 1'b1;
					flag_wd  = 1'b0;
					used_d   = used_total_q - 1'b1;
					ok_c     = 1'b1;
					res_c    = idx;
				end
			end
			pllm_pkg::OP_NEXT: begin
				if (item_s1.from_start) begin
					if (!list_empty) begin
						ok_c  = 1'b1;
						res_c = list_head_q;
					end
				end else if (idx_used && !is_tail) begin
					ok_c  = 1'b1;
					res_c = next_rd_s1;
				end
			end
			pllm_pkg::OP_CHECK: begin
				if (idx_used) begin
					ok_c  = 1'b1;
					res_c = idx;
				end
			end
			default: begin
			end
		endcase
	end

	// memories: reads launched on the request transfer, writes on commit
	always_ff @(posedge clk) begin
		if (busy_q && next_we)
			next_mem[next_wa] <= next_wd;
		if (req_xfer)
			next_rd_s1 <= next_mem[req.entry_index];
	end

	always_ff @(posedge clk) begin
		if (busy_q && prev_we)
			prev_mem[prev_wa] <= prev_wd;
		if (req_xfer)
			prev_rd_s1 <= prev_mem[req.entry_index];
	end

	always_ff @(posedge clk) begin
		if (busy_q && free_we)
			free_mem[free_wa] <= free_wd;
		if (req_xfer)
			free_rd_s1 <= free_mem[free_head_q];
	end

	always_ff @(posedge clk) begin
		if (req_xfer)
			item_s1 <= req;
		if (busy_q) begin
			rsp_q.ok           <= ok_c;
			rsp_q.result_index <= res_c;
			rsp_q.in_use_count <= used_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			in_use_q     <= '0;
			list_head_q  <= '0;
			list_tail_q  <= '0;
			free_head_q  <= '0;
			free_tail_q  <= '0;
			free_empty_q <= 1'b1;
			fresh_next_q <= '0;
			used_total_q <= '0;
			pool_size_q  <= CW'(NE);
		end else begin
			if (cfg_xfer) begin
				pool_size_q  <= cfg_size;
				in_use_q     <= '0;
				free_empty_q <= 1'b1;
				fresh_next_q <= '0;
				used_total_q <= '0;
			end else if (busy_q) begin
				if (flag_we)
					in_use_q[flag_wa] <= flag_wd;
				list_head_q  <= head_d;
				list_tail_q  <= tail_d;
				free_head_q  <= fhead_d;
				free_tail_q  <= ftail_d;
				free_empty_q <= fempty_d;
				fresh_next_q <= fresh_d;
				used_total_q <= used_d;
			end
			busy_q <= req_xfer;
			if (busy_q)
				rsp_valid_q <= 1'b1;
			else if (rsp_xfer)
				rsp_valid_q <= 1'b0;
		end
	end

	`PLLM_ASSERT_IMPL(a_rsp_follows_req, req_valid && req_ready, ##2 rsp_valid)
	`PLLM_ASSERT_IMPL(a_used_within_pool, 1'b1, used_total_q <= pool_size_q)
	`PLLM_ASSERT_IMPL(a_fresh_within_pool, 1'b1, fresh_next_q <= pool_size_q)
	`PLLM_ASSERT_NEXT(a_cfg_empties_list, cfg_valid && cfg_ready, used_total_q == '0)

endmodule

`default_nettype wire

FILE: dv/pool_linked_list_manager_test.sv
// ----------------------------------------------------------------------------
// pool_linked_list_manager_test
// Self-checking bench for the pool linked list manager. A behavioral copy of
// the in-use list and free FIFO predicts every response. Requests run in
// bursts with random gaps, the response side stalls on its own pattern, and
// the pool size is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module pool_linked_list_manager_test;

	localparam int unsigned ENTRY_W     = pllm_pkg::ENTRY_W;
	localparam int unsigned COUNT_W     = pllm_pkg::COUNT_W;
	localparam int unsigned MAX_ENTRIES = pllm_pkg::MAX_ENTRIES;

	localparam logic [COUNT_W-1:0] NO_ENTRY     = COUNT_W'(MAX_ENTRIES);
	localparam logic [2:0]         OP_UNUSED_LO = 3'd5;
	localparam logic [2:0]         OP_UNUSED_HI = 3'd7;
	localparam int                 SHOWN_MAX    = 10;
	localparam int                 DRAIN_CYCLES = 8;
	localparam int                 RUN_LIMIT    = 20_000_000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	pllm_pkg::pllm_req_t req       = '0;
	logic                rsp_ready = 1'b0;
	logic                cfg_valid = 1'b0;
	logic [COUNT_W-1:0]  cfg_data  = '0;
	logic                req_ready;
	logic                rsp_valid;
	logic                cfg_ready;
	pllm_pkg::pllm_rsp_t rsp;

	pool_linked_list_manager DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// behavioral copy of the lists
	logic [COUNT_W-1:0] fwd_link [MAX_ENTRIES];
	logic [COUNT_W-1:0] back_link[MAX_ENTRIES];
	bit                 in_use   [MAX_ENTRIES];
	logic [COUNT_W-1:0] list_first, list_last, free_first, free_last;
	logic [COUNT_W-1:0] fresh_cnt, live_cnt, pool_sz;
	logic [ENTRY_W-1:0] walk_at;

	pllm_pkg::pllm_rsp_t awaited_rsp[$];

	int sent_cnt, got_cnt, fault_cnt, cfg_writes;
	int dry_hits, bad_frees, empty_walks;
	int rx_run, rx_pick;

	function automatic void clear_pool();
		foreach (in_use[i]) in_use[i] = 1'b0;
		list_first = NO_ENTRY;
		list_last  = NO_ENTRY;
		free_first = NO_ENTRY;
		free_last  = NO_ENTRY;
		fresh_cnt  = '0;
		live_cnt   = '0;
		walk_at    = '0;
	endfunction

	// never-used entries first, then the free FIFO
	function automatic logic [COUNT_W-1:0] take_entry();
		logic [COUNT_W-1:0] e;
		e = NO_ENTRY;
		if (fresh_cnt < pool_sz) begin
			e = fresh_cnt;
			fresh_cnt++;
		end else if (free_first != NO_ENTRY) begin
			e = free_first;
			free_first = fwd_link[e[ENTRY_W-1:0]];
			if (free_first >= NO_ENTRY) begin
				free_first = NO_ENTRY;
				free_last  = NO_ENTRY;
			end
		end
		return e;
	endfunction

	function automatic bit is_live(logic [ENTRY_W-1:0] idx);
		return (COUNT_W'(idx) < pool_sz) && in_use[idx];
	endfunction

	function automatic pllm_pkg::pllm_rsp_t pool_response(pllm_pkg::pllm_req_t r);
		logic [COUNT_W-1:0]  e, n, p;
		logic [ENTRY_W-1:0]  idx, pick;
		bit                  hit;
		pllm_pkg::pllm_rsp_t o;
		idx  = r.entry_index;
		pick = '0;
		hit  = 1'b0;
		case (r.op)
			pllm_pkg::OP_ALLOC_HEAD, pllm_pkg::OP_ALLOC_TAIL: begin
				e = take_entry();
				if (e == NO_ENTRY) begin
					dry_hits++;
				end else begin
					if (r.op == pllm_pkg::OP_ALLOC_HEAD) begin
						fwd_link[e[ENTRY_W-1:0]]  = list_first;
						back_link[e[ENTRY_W-1:0]] = NO_ENTRY;
						if (list_first != NO_ENTRY)
							back_link[list_first[ENTRY_W-1:0]] = e;
						else
							list_last = e;
						list_first = e;
					end else begin
						back_link[e[ENTRY_W-1:0]] = list_last;
						fwd_link[e[ENTRY_W-1:0]]  = NO_ENTRY;
						if (list_last != NO_ENTRY)
							fwd_link[list_last[ENTRY_W-1:0]] = e;
						else
							list_first = e;
						list_last = e;
					end
					in_use[e[ENTRY_W-1:0]] = 1'b1;
					live_cnt++;
					hit  = 1'b1;
					pick = e[ENTRY_W-1:0];
				end
			end
			pllm_pkg::OP_FREE: begin
				if (is_live(idx)) begin
					n = fwd_link[idx];
					p = back_link[idx];
					if (n != NO_ENTRY)
						back_link[n[ENTRY_W-1:0]] = p;
					else
						list_last = p;
					if (p != NO_ENTRY)
						fwd_link[p[ENTRY_W-1:0]] = n;
					else
						list_first = n;
					fwd_link[idx]  = NO_ENTRY;
					back_link[idx] = free_last;
					if (free_last != NO_ENTRY)
						fwd_link[free_last[ENTRY_W-1:0]] = COUNT_W'(idx);
					else
						free_first = COUNT_W'(idx);
					free_last   = COUNT_W'(idx);
					in_use[idx] = 1'b0;
					live_cnt--;
					hit  = 1'b1;
					pick = idx;
				end else begin
					bad_frees++;
				end
			end
			pllm_pkg::OP_NEXT: begin
				if (r.from_start) begin
					if (list_first != NO_ENTRY) begin
						hit  = 1'b1;
						pick = list_first[ENTRY_W-1:0];
					end
				end else if (is_live(idx) && fwd_link[idx] != NO_ENTRY) begin
					hit  = 1'b1;
					pick = fwd_link[idx][ENTRY_W-1:0];
				end
				if (hit)
					walk_at = pick;
				else
					empty_walks++;
			end
			pllm_pkg::OP_CHECK: begin
				if (is_live(idx)) begin
					hit  = 1'b1;
					pick = idx;
				end
			end
			default: ;
		endcase
		o.ok           = hit;
		o.result_index = pick;
		o.in_use_count = live_cnt;
		return o;
	endfunction

	function automatic pllm_pkg::pllm_req_t make_req(pllm_pkg::pllm_op_t op, int idx,
			bit from_start);
		pllm_pkg::pllm_req_t r;
		r.op          = op;
		r.entry_index = ENTRY_W'(idx);
		r.from_start  = from_start;
		return r;
	endfunction

	// mostly entries that are in use, some free or out of range
	function automatic logic [ENTRY_W-1:0] pick_index();
		int roll, k;
		roll = $urandom_range(0, 9);
		if (roll < 6) begin
			repeat (8) begin
				k = $urandom_range(0, pool_sz - 1);
				if (in_use[k])
					return ENTRY_W'(k);
			end
		end
		if (roll < 9)
			return ENTRY_W'($urandom_range(0, pool_sz - 1));
		return ENTRY_W'($urandom_range(0, MAX_ENTRIES - 1));
	endfunction

	function automatic pllm_pkg::pllm_req_t random_req(int alloc_pct);
		pllm_pkg::pllm_req_t r;
		int                  roll;
		r.entry_index = pick_index();
		r.from_start  = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (roll < alloc_pct) begin
			r.op = $urandom_range(0, 1) ? pllm_pkg::OP_ALLOC_TAIL : pllm_pkg::OP_ALLOC_HEAD;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				r.op = pllm_pkg::OP_FREE;
			end else if (roll < 70) begin
				r.op = pllm_pkg::OP_NEXT;
				r.from_start = ($urandom_range(0, 4) == 0);
				if (!r.from_start && $urandom_range(0, 9) < 6)
					r.entry_index = walk_at;
			end else if (roll < 95) begin
				r.op = pllm_pkg::OP_CHECK;
			end else begin
				r.op = pllm_pkg::pllm_op_t'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			end
		end
		return r;
	endfunction

	// called at a rising edge; returns at the edge where the transfer happens
	task automatic send_request(pllm_pkg::pllm_req_t r);
		bit taken;
		taken = 1'b0;
		req_valid <= 1'b1;
		req       <= r;
		while (!taken) begin
			@(negedge clk);
			if (req_ready) begin
				taken = 1'b1;
				awaited_rsp.push_back(pool_response(r));
				sent_cnt++;
			end
			@(posedge clk);
		end
	endtask

	task automatic hold_off(int cycles);
		if (cycles > 0) begin
			req_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_pool_size(logic [COUNT_W-1:0] value);
		bit taken;
		wait_drained();
		taken = 1'b0;
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		while (!taken) begin
			@(negedge clk);
			if (cfg_ready) begin
				taken = 1'b1;
				pool_sz = value;
				if (pool_sz == 0)
					pool_sz = 1;
				if (pool_sz > MAX_ENTRIES)
					pool_sz = NO_ENTRY;
				clear_pool();
				cfg_writes++;
			end
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(int count, int alloc_pct, int gap_max, int pause_at);
		int burst_left;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_drained();
			if (burst_left == 0) begin
				hold_off(gap_max > 0 ? $urandom_range(0, gap_max) : 0);
				burst_left = $urandom_range(1, 16);
			end
			send_request(random_req(alloc_pct));
			burst_left--;
		end
	endtask

	task automatic test_directed();
		send_request(make_req(pllm_pkg::OP_CHECK, 0, 1'b0));
		send_request(make_req(pllm_pkg::OP_NEXT, 0, 1'b1));      // empty list
		send_request(make_req(pllm_pkg::OP_NEXT, 255, 1'b0));    // step from unused entry
		send_request(make_req(pllm_pkg::OP_FREE, 0, 1'b0));      // free of unused entry
		send_request(make_req(pllm_pkg::OP_ALLOC_HEAD, 255, 1'b1));
		send_request(make_req(pllm_pkg::OP_ALLOC_TAIL, 0, 1'b0));
		send_request(make_req(pllm_pkg::OP_ALLOC_HEAD, 0, 1'b0));
		send_request(make_req(pllm_pkg::OP_NEXT, 255, 1'b1));
		send_request(make_req(pllm_pkg::OP_NEXT, 2, 1'b0));
		send_request(make_req(pllm_pkg::OP_NEXT, 0, 1'b0));
		send_request(make_req(pllm_pkg::OP_NEXT, 1, 1'b0));      // at the tail
		send_request(make_req(pllm_pkg::OP_CHECK, 255, 1'b1));
		send_request(make_req(pllm_pkg::OP_FREE, 0, 1'b0));      // unlink from the middle
		send_request(make_req(pllm_pkg::OP_FREE, 0, 1'b0));
		send_request(make_req(pllm_pkg::pllm_op_t'(OP_UNUSED_HI), 255, 1'b1));
		send_request(make_req(pllm_pkg::pllm_op_t'(OP_UNUSED_LO), 0, 1'b0));
		send_request(make_req(pllm_pkg::OP_ALLOC_TAIL, 0, 1'b0));
		// zero is taken as a pool of one
		write_pool_size('0);
		send_request(make_req(pllm_pkg::OP_ALLOC_TAIL, 0, 1'b0));
		send_request(make_req(pllm_pkg::OP_ALLOC_HEAD, 0, 1'b0)); // pool dry
		send_request(make_req(pllm_pkg::OP_CHECK, 1, 1'b0));      // out of range
		send_request(make_req(pllm_pkg::OP_FREE, 1, 1'b0));
		send_request(make_req(pllm_pkg::OP_FREE, 0, 1'b0));
		send_request(make_req(pllm_pkg::OP_ALLOC_HEAD, 0, 1'b0)); // back from the free FIFO
		send_request(make_req(pllm_pkg::OP_NEXT, 0, 1'b1));
		write_pool_size('1);                                      // clamped to the maximum
	endtask

	task automatic test_fill_and_drain();
		write_pool_size(COUNT_W'(MAX_ENTRIES));
		run_random(300, 90, 3, 150);
		run_random(150, 10, 0, -1);
	endtask

	task automatic test_pool_sizes();
		write_pool_size(COUNT_W'(1));
		run_random(150, 50, 5, -1);
		write_pool_size(COUNT_W'(2));
		run_random(150, 45, 0, -1);
		write_pool_size(COUNT_W'(300));
		run_random(150, 55, 5, 75);
		for (int k = 0; k < 3; k++) begin
			write_pool_size(COUNT_W'($urandom_range(3, 16)));
			run_random(150, 45, 4, -1);
		end
		write_pool_size(COUNT_W'($urandom_range(17, MAX_ENTRIES)));
		run_random(150, 60, 2, -1);
		write_pool_size(COUNT_W'(MAX_ENTRIES - 1));
		run_random(150, 50, 5, -1);
	endtask

	// churn through a small pool so that entries cycle through the free FIFO
	task automatic test_free_fifo_reuse();
		write_pool_size(COUNT_W'(4));
		run_random(300, 50, 3, 120);
	endtask

	// response side: its own mix of short stalls, long stalls and open stretches
	always @(posedge clk) begin
		if (rx_run == 0) begin
			rx_pick = $urandom_range(0, 15);
			if (rx_pick < 8) begin
				rsp_ready <= 1'b1;
				rx_run = $urandom_range(1, 12);
			end else if (rx_pick < 13) begin
				rsp_ready <= 1'b0;
				rx_run = $urandom_range(1, 4);
			end else if (rx_pick < 15) begin
				rsp_ready <= 1'b1;
				rx_run = $urandom_range(40, 120);
			end else begin
				rsp_ready <= 1'b0;
				rx_run = $urandom_range(10, 24);
			end
		end else begin
			rx_run--;
		end
	end

	task automatic note_fault(string what, pllm_pkg::pllm_rsp_t want,
			pllm_pkg::pllm_rsp_t seen);
		fault_cnt++;
		if (fault_cnt <= SHOWN_MAX)
			$display("%0t %s: expected ok=%0b idx=%0d count=%0d, got ok=%0b idx=%0d count=%0d",
				$realtime, what, want.ok, want.result_index, want.in_use_count,
				seen.ok, seen.result_index, seen.in_use_count);
	endtask

	always @(negedge clk) begin : rsp_check
		pllm_pkg::pllm_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			got_cnt++;
			if (awaited_rsp.size() == 0) begin
				note_fault("unexpected response", '0, rsp);
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.ok !== want.ok || rsp.result_index !== want.result_index ||
						rsp.in_use_count !== want.in_use_count)
					note_fault("response mismatch", want, rsp);
			end
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("[pool_linked_list_manager] ERROR");
		$finish;
	end

	initial begin
		int fails;
		pool_sz = NO_ENTRY;
		clear_pool();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_drain();
		test_pool_sizes();
		test_free_fifo_reuse();
		wait_drained();
		fails = fault_cnt + awaited_rsp.size();
		$display("Ran %0d requests, %0d responses checked, over %0d pool size writes.",
			sent_cnt, got_cnt, cfg_writes);
		$display("Pool ran dry %0d times, %0d frees rejected, %0d walks found no entry.",
			dry_hits, bad_frees, empty_walks);
		if (fails == 0)
			$display("[pool_linked_list_manager] OK");
		else
			$display("[pool_linked_list_manager] ERROR");
		$finish;
	end

endmodule
